// ===== src/kpcss_pkg.sv =====
// Package for the serial keypad controller.
// Holds the beat kinds, frame constants and the frame assembly function.
// Depends on nothing; the interface, pad and top-level files and the testbench import it.
package kpcss_pkg;

   localparam int unsigned FrameBits = 32;
   localparam int unsigned ButtonsW  = 27;
   localparam int unsigned PadW      = 4;

   // Kind of a request beat.
   typedef enum logic {
      REQ_LATCH = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   // Live direction buttons handed to the pad resolver.
   typedef struct packed {
      logic right;
      logic left;
      logic down;
      logic up;
   } dir_type;

   // Frame image after reset: empty snapshot and pad, signature 1,0,1,1 in place.
   localparam logic [FrameBits-1:0] ResetFrame = 32'h0000_D000;

   // Builds the 32-bit serial frame, bit 0 is shifted out first.
   function automatic logic [FrameBits-1:0] frame_word(
      input logic [ButtonsW-1:0] snap,
      input logic [PadW-1:0]     pad
   );
      logic [FrameBits-1:0] f;
      f[3:0]   = snap[3:0];
      f[7:4]   = pad;
      f[11:8]  = snap[11:8];
      f[15:12] = 4'b1101;
      f[29:16] = snap[25:12];
      f[30]    = 1'b0;
      f[31]    = snap[26];
      return f;
   endfunction

endpackage

// ===== src/kpcss_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on kpcss_pkg for the field widths.
interface kpcss_req_if import kpcss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic                latch_level;
   logic [ButtonsW-1:0] buttons;

   modport source (output valid, output req_type, output latch_level, output buttons,
                   input ready);
   modport sink   (input valid, input req_type, input latch_level, input buttons,
                   output ready);
endinterface

interface kpcss_rsp_if ();
   logic valid;
   logic ready;
   logic data_bit;

   modport source (output valid, output data_bit, input ready);
   modport sink   (input valid, input data_bit, output ready);
endinterface

// ===== src/kpcss_cell.sv =====
// One cell of the serial frame chain: a single stored bit that can be
// loaded in parallel or take its neighbor's bit. Depends on nothing.
module kpcss_cell #(
   parameter logic RstBit = 1'b0
) (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic shift,
   input  logic load_bit,
   input  logic shift_in,
   output logic q
);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= RstBit;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign q = bit_ff;

endmodule

// ===== src/kpcss_pad.sv =====
// Direction pad resolver: keeps the latched directions and the two
// conflict-hold flags. Depends on kpcss_pkg.
module kpcss_pad import kpcss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            update,
   input  dir_type         dir,
   output logic [PadW-1:0] pad_next
);

   logic [PadW-1:0] pad_ff;
   logic [PadW-1:0] pad_in;
   logic            vhold_ff;
   logic            vhold_in;
   logic            hhold_ff;
   logic            hhold_in;

   always_comb begin
      pad_in   = pad_ff;
      vhold_in = vhold_ff;
      hhold_in = hhold_ff;
      // An opposing pair swaps the previous pair once, then holds it.
      if (!(dir.up && dir.down)) begin
         vhold_in   = 1'b0;
         pad_in[1:0] = {dir.down, dir.up};
      end else if (!vhold_ff) begin
         vhold_in   = 1'b1;
         pad_in[1:0] = {pad_ff[0], pad_ff[1]};
      end
      if (!(dir.left && dir.right)) begin
         hhold_in   = 1'b0;
         pad_in[3:2] = {dir.right, dir.left};
      end else if (!hhold_ff) begin
         hhold_in   = 1'b1;
         pad_in[3:2] = {pad_ff[2], pad_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff   <= '0;
         vhold_ff <= 1'b0;
         hhold_ff <= 1'b0;
      end else if (update) begin
         pad_ff   <= pad_in;
         vhold_ff <= vhold_in;
         hhold_ff <= hhold_in;
      end
   end

   assign pad_next = pad_in;

endmodule

// ===== src/keypad_controller_serial_shifter.sv =====
// Top level of the serial latch-and-shift keypad controller.
// Depends on kpcss_pkg, kpcss_if, kpcss_cell and kpcss_pad.
//
// This block models a game pad with an extra numeric keypad as seen on its
// serial latch and data lines. Each request beat is either a latch-line
// write or a data-line read, and every beat carries the live state of all
// 27 buttons. A falling latch captures the buttons, resolves opposing
// direction pairs and loads the 32-bit frame in parallel into a chain of 32
// one-bit cells. Every read with the latch low takes the bit at the head of
// the chain and moves each cell's bit one place toward the head, while a 1
// enters at the tail, so that once the frame is out every further read
// returns 1. With the latch high a read returns the live B button and the
// chain holds still. A latch write at the level already held does nothing.
// Latch writes produce no response beat; every read produces exactly one.
// The block takes one request beat per clock cycle while not stalled, and a
// read's response beat is registered in the cycle after it is accepted. The
// request side stalls only while the output register holds a beat that the
// sink has not yet taken, so with a ready sink reads stream at full rate.
module keypad_controller_serial_shifter import kpcss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kpcss_req_if.sink   req,
   kpcss_rsp_if.source rsp
);

   logic                 latch_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_data_ff;
   logic                 req_fire;
   logic                 is_read;
   logic                 latch_fall;
   logic                 latch_chg;
   logic                 chain_shift;
   logic [FrameBits-1:0] cell_q;
   logic [FrameBits-1:0] load_word;
   logic [PadW-1:0]      pad_next;
   dir_type              dir;

   // Output register frees up when the sink takes its beat.
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_fire   = req.valid && req.ready;
   assign is_read    = (req.req_type == REQ_READ);
   assign latch_chg  = req_fire && !is_read && (req.latch_level != latch_ff);
   assign latch_fall = latch_chg && !req.latch_level;
   // Reads with the latch low move the frame one place toward the head.
   assign chain_shift = req_fire && is_read && !latch_ff;

   assign dir.up    = req.buttons[4];
   assign dir.down  = req.buttons[5];
   assign dir.left  = req.buttons[6];
   assign dir.right = req.buttons[7];

   kpcss_pad u_pad (
      .clock    (clock),
      .reset    (reset),
      .update   (latch_fall),
      .dir      (dir),
      .pad_next (pad_next)
   );

   assign load_word = frame_word(req.buttons, pad_next);

   // The chain of cells; cell 0 is the head, and the tail fills with ones.
   for (genvar i = 0; i < FrameBits; i++) begin : g_cell
      logic nbr;
      if (i == FrameBits - 1) begin : g_tail
         assign nbr = 1'b1;
      end else begin : g_body
         assign nbr = cell_q[i+1];
      end
      kpcss_cell #(
         .RstBit (ResetFrame[i])
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (latch_fall),
         .shift    (chain_shift),
         .load_bit (load_word[i]),
         .shift_in (nbr),
         .q        (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= 1'b0;
      end else begin
         if (latch_chg) begin
            latch_ff <= req.latch_level;
         end
         if (req_fire && is_read) begin
            rsp_valid_ff <= 1'b1;
            // Latched reads see the live B button, otherwise the chain head.
            rsp_data_ff  <= latch_ff ? req.buttons[0] : cell_q[0];
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_bit = rsp_data_ff;

`ifndef ASSERT_OFF
   // A read always leaves a response beat waiting in the output register.
   a_read_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_read |=> rsp_valid_ff)
      else $error("read did not produce a response beat");

   // A latch write never creates a response beat.
   a_latch_no_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_read |=> !$rose(rsp_valid_ff))
      else $error("latch write produced a response beat");

   // While the latch is high the frame chain moves only on a falling latch.
   a_chain_held: assert property (@(posedge clock) disable iff (reset)
      latch_ff && !latch_fall |=> $stable(cell_q))
      else $error("frame chain changed while latched");

   // After a shifting read the tail cell holds a one.
   a_tail_fill: assert property (@(posedge clock) disable iff (reset)
      chain_shift |=> cell_q[FrameBits-1])
      else $error("tail cell not filled with one");
`endif

endmodule

// ===== test/tb_keypad_controller_serial_shifter.sv =====
// Self-checking testbench for the serial latch-and-shift keypad controller.
// Depends on kpcss_pkg, the kpcss_req_if/kpcss_rsp_if interfaces and the top level.
// It drives latch and read beats, predicts each data bit and checks every response.
module tb_keypad_controller_serial_shifter import kpcss_pkg::*;;

   // One request beat as the driver sees it.
   typedef struct packed {
      req_kind_type        kind;
      logic                level;
      logic [ButtonsW-1:0] buttons;
   } beat_type;

   // Frame positions 12..15 carry this fixed signature, lowest bit first.
   localparam logic [3:0] Signature  = 4'b1101;
   localparam int         CycleLimit = 400000;
   localparam int         HoldCycles = 150;
   localparam int         MaxReports = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kpcss_req_if req_ch ();
   kpcss_rsp_if rsp_ch ();

   keypad_controller_serial_shifter i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus waiting for the driver, and data bits waiting for the monitor.
   beat_type pending_beats[$];
   logic     expected_bits[$];
   beat_type cur_beat;

   // Predicted controller state.
   logic                latch_q;
   logic [5:0]          frame_pos;
   logic [ButtonsW-1:0] snap_q;
   logic [PadW-1:0]     pad_q;
   logic                vert_hold_q;
   logic                horz_hold_q;

   // Idling control shared by the stimulus thread and both channel processes.
   bit idle_on      = 1'b0;
   int send_gap     = 0;
   int recv_gap     = 0;
   int hold_request = 0;

   int cycle_count    = 0;
   int beats_taken    = 0;
   int bits_checked   = 0;
   int error_count    = 0;
   int latch_falls    = 0;
   int held_conflicts = 0;
   int beats_queued   = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Bit of the serial frame at a given shift position, built from the
   // predicted snapshot and the resolved direction pad.
   function automatic logic frame_bit_at(input logic [5:0] pos);
      if (pos < 4)  return snap_q[pos];
      if (pos < 8)  return pad_q[pos - 4];
      if (pos < 12) return snap_q[pos];
      if (pos < 16) return Signature[pos - 12];
      if (pos < 30) return snap_q[pos - 4];
      if (pos == 30) return 1'b0;
      return snap_q[26];
   endfunction

   // Advances the predicted state by one accepted beat and queues the data
   // bit that a read must return.
   task automatic predict_beat(input beat_type b);
      logic up, dn, lf, rt;
      if (b.kind == REQ_LATCH) begin
         if (b.level != latch_q) begin
            latch_q   = b.level;
            frame_pos = '0;
            if (!b.level) begin
               // A falling latch captures the buttons and resolves the pad.
               {rt, lf, dn, up} = b.buttons[7:4];
               snap_q = b.buttons;
               latch_falls++;
               if (!(up && dn)) begin
                  vert_hold_q = 1'b0;
                  pad_q[1:0]  = {dn, up};
               end else if (!vert_hold_q) begin
                  // First conflicting capture swaps the previous pair once.
                  vert_hold_q = 1'b1;
                  pad_q[1:0]  = {pad_q[0], pad_q[1]};
                  held_conflicts++;
               end
               if (!(lf && rt)) begin
                  horz_hold_q = 1'b0;
                  pad_q[3:2]  = {rt, lf};
               end else if (!horz_hold_q) begin
                  horz_hold_q = 1'b1;
                  pad_q[3:2]  = {pad_q[2], pad_q[3]};
                  held_conflicts++;
               end
            end
         end
      end else if (latch_q) begin
         // While latched the data line follows the live B button.
         expected_bits.push_back(b.buttons[0]);
      end else if (frame_pos < FrameBits) begin
         expected_bits.push_back(frame_bit_at(frame_pos));
         frame_pos++;
      end else begin
         expected_bits.push_back(1'b1);
      end
   endtask

   // Request driver. A beat that is offered but not yet taken is held
   // unchanged; otherwise the driver may open an idle burst or present the
   // next pending beat. Each signal gets one nonblocking write per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.req_type    <= REQ_LATCH;
         req_ch.latch_level <= 1'b0;
         req_ch.buttons     <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_beat(cur_beat);
            beats_taken++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
               // This cycle is the first of the burst.
               send_gap     = $urandom_range(1, 19) - 1;
               req_ch.valid <= 1'b0;
            end else begin
               cur_beat = pending_beats.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.req_type    <= cur_beat.kind;
               req_ch.latch_level <= cur_beat.level;
               req_ch.buttons     <= cur_beat.buttons;
            end
         end
      end
   end

   // Response monitor and sink. Every accepted beat is checked against the
   // oldest predicted bit. A long hold-off asked for by the stimulus thread
   // is counted down here, cycle by cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bits.size() == 0) begin
               error_count++;
               if (error_count <= MaxReports)
                  $display("unexpected data beat %0b at cycle %0d", rsp_ch.data_bit,
                           cycle_count);
            end else begin
               if (rsp_ch.data_bit !== expected_bits[0]) begin
                  error_count++;
                  if (error_count <= MaxReports)
                     $display("data bit %0d: expected %0b, got %0b", bits_checked,
                              expected_bits[0], rsp_ch.data_bit);
               end
               void'(expected_bits.pop_front());
               bits_checked++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request > 0) begin
            recv_gap     = hold_request - 1;
            hold_request = 0;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_gap     = $urandom_range(1, 19) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic add_beat(input req_kind_type kind, input logic level,
                           input logic [ButtonsW-1:0] buttons);
      beat_type b;
      b.kind    = kind;
      b.level   = level;
      b.buttons = buttons;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   // Random buttons, with opposing direction pairs pressed together often
   // enough that the hold logic is exercised.
   function automatic logic [ButtonsW-1:0] random_buttons();
      logic [ButtonsW-1:0] btn;
      btn = ButtonsW'($urandom);
      case ($urandom_range(0, 5))
         0: btn[5:4] = 2'b11;
         1: btn[7:6] = 2'b11;
         2: btn[7:4] = 4'b1111;
         default: ;
      endcase
      return btn;
   endfunction

   // One polling sequence: raise the latch, maybe sample B, drop the latch
   // to capture, then clock out a frame. Now and then a stray beat is mixed in.
   task automatic add_poll();
      int reads;
      repeat ($urandom_range(0, 2))
         add_beat(REQ_READ, 1'($urandom), random_buttons());
      add_beat(REQ_LATCH, 1'b1, random_buttons());
      repeat ($urandom_range(0, 2))
         add_beat(REQ_READ, 1'($urandom), random_buttons());
      if ($urandom_range(0, 7) == 0)
         add_beat(REQ_LATCH, 1'b1, random_buttons());
      add_beat(REQ_LATCH, 1'b0, random_buttons());
      if ($urandom_range(0, 9) < 7)
         reads = $urandom_range(32, 36);
      else
         reads = $urandom_range(0, 40);
      repeat (reads) begin
         if ($urandom_range(0, 39) == 0)
            add_beat(req_kind_type'($urandom_range(0, 1)), 1'($urandom), random_buttons());
         else
            add_beat(REQ_READ, 1'($urandom), random_buttons());
      end
   endtask

   task automatic add_random_polls(input int count);
      int stop_at;
      stop_at = beats_queued + count;
      while (beats_queued < stop_at)
         add_poll();
   endtask

   // Blocks the stimulus until every queued beat is taken and every
   // predicted bit has come back, then lets the output register settle.
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_ch.valid || expected_bits.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : watchdog
      wait (cycle_count >= CycleLimit);
      $display("timeout after %0d cycles, %0d bits still expected", cycle_count,
               expected_bits.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase_base;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_LATCH;
      req_ch.latch_level = 1'b0;
      req_ch.buttons     = '0;
      rsp_ch.ready       = 1'b0;
      latch_q     = 1'b0;
      frame_pos   = '0;
      snap_q      = '0;
      pad_q       = '0;
      vert_hold_q = 1'b0;
      horz_hold_q = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reads from the reset frame, a latch write at the
      // level already held, reads of live B while latched, a plain capture,
      // a first opposing-pair capture that swaps the pad, a second one that
      // holds it, and a clean capture that releases both holds.
      add_beat(REQ_READ,  1'b0, {ButtonsW{1'b1}});
      add_beat(REQ_READ,  1'b1, '0);
      add_beat(REQ_LATCH, 1'b0, {ButtonsW{1'b1}});
      add_beat(REQ_LATCH, 1'b1, '0);
      add_beat(REQ_READ,  1'b0, 27'h0000001);
      add_beat(REQ_READ,  1'b0, 27'h7FFFFFE);
      add_beat(REQ_LATCH, 1'b1, {ButtonsW{1'b1}});
      add_beat(REQ_LATCH, 1'b0, 27'h0000050);
      add_beat(REQ_READ,  1'b0, '0);
      add_beat(REQ_LATCH, 1'b1, '0);
      add_beat(REQ_LATCH, 1'b0, {ButtonsW{1'b1}});
      add_beat(REQ_LATCH, 1'b1, '0);
      add_beat(REQ_LATCH, 1'b0, {ButtonsW{1'b1}});
      repeat (6) add_beat(REQ_READ, 1'b1, '0);
      add_beat(REQ_LATCH, 1'b1, '0);
      add_beat(REQ_LATCH, 1'b0, '0);
      repeat (5) add_beat(REQ_READ, 1'b0, {ButtonsW{1'b1}});
      wait_drained();

      // Random polling with idling on both sides. Partway through, the sink
      // stops for a long stretch while the driver keeps offering beats, so
      // the output register fills and the request side stalls.
      idle_on    = 1'b1;
      phase_base = beats_taken;
      add_random_polls(700);
      while (beats_taken < phase_base + 200) @(negedge clock);
      hold_request = HoldCycles;
      wait_drained();

      add_random_polls(500);
      wait_drained();

      // Closing stretch at full rate on both sides.
      idle_on = 1'b0;
      add_random_polls(250);
      wait_drained();

      $display("covered %0d request beats and %0d checked data bits over %0d cycles",
               beats_taken, bits_checked, cycle_count);
      $display("captures: %0d falling latches, %0d opposing-pair swaps; mismatches: %0d",
               latch_falls, held_conflicts, error_count);
      if (error_count == 0 && expected_bits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
